/* src/hsef_pkg.sv */
`default_nettype none
package hsef_pkg;

  localparam int IDX_W     = 16;
  localparam int COORD_W   = 32;
  localparam int DELTA_W   = COORD_W + 1;
  localparam int MAG_W     = COORD_W + 1;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int D2_W      = SQ_W + 2;
  localparam int ROOT_W    = D2_W / 2;
  localparam int DIFF_W    = ROOT_W + 1;
  localparam int PK_W      = COORD_W + ROOT_W;
  localparam int DSQ_W     = 2 * ROOT_W;
  localparam int NUM_W     = PK_W + MAG_W;
  localparam int ESUM_W    = DSQ_W + COORD_W;
  localparam int ENERGY_W  = 63;
  localparam int GRAD_W    = 48;
  localparam int LANES     = 3;

  localparam int DEF_ATOM_INDEX_BITS = 16;
  localparam int DEF_FRAC_BITS       = 16;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX   = {ENERGY_W{1'b1}};
  localparam logic [63:0]         GRAD_POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0]         GRAD_NEG_MAG = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic [IDX_W-1:0]                 ida;
    logic [IDX_W-1:0]                 idb;
    logic                             last;
    logic [LANES-1:0]                 sgn;
    logic [LANES-1:0][MAG_W-1:0]      dmag;
    logic [COORD_W-1:0]               len;
    logic [COORD_W-1:0]               k;
  } sq_tag_t;

  typedef struct packed {
    logic [IDX_W-1:0]    ida;
    logic [IDX_W-1:0]    idb;
    logic                last;
    logic                zero;
    logic [LANES-1:0]    neg;
    logic [ENERGY_W-1:0] energy;
  } div_tag_t;

endpackage
`default_nettype wire

/* src/hsef_sqrt.sv */
`default_nettype none
module hsef_sqrt import hsef_pkg::*; #(
  parameter int RAD_W = D2_W,
  parameter int TAG_W = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_vld,
  input  wire logic [RAD_W-1:0]     rad,
  input  wire logic [TAG_W-1:0]     tag_in,
  output logic                      out_vld,
  output logic [RAD_W/2-1:0]        root,
  output logic [TAG_W-1:0]          tag_out
);

  localparam int N  = RAD_W / 2;
  localparam int RW = N + 2;

  logic             vld    [N];
  logic [RW-1:0]    rem_q  [N];
  logic [N-1:0]     root_q [N];
  logic [RAD_W-1:0] rad_q  [N];
  logic [TAG_W-1:0] tag_q  [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic             p_vld;
    logic [RW-1:0]    p_rem;
    logic [N-1:0]     p_root;
    logic [RAD_W-1:0] p_rad;
    logic [TAG_W-1:0] p_tag;
    logic [RW+1:0]    r_sh;
    logic [RW+1:0]    trial;
    logic [RW+2:0]    sub;

    if (s == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = rad;
      assign p_tag  = tag_in;
    end else begin : g_next
      assign p_vld  = vld[s-1];
      assign p_rem  = rem_q[s-1];
      assign p_root = root_q[s-1];
      assign p_rad  = rad_q[s-1];
      assign p_tag  = tag_q[s-1];
    end

    assign r_sh  = {p_rem, p_rad[RAD_W-1 -: 2]};
    assign trial = {2'b00, p_root, 2'b01};
    assign sub   = {1'b0, r_sh} - {1'b0, trial};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[s] <= p_rad << 2;
        tag_q[s] <= p_tag;
        if (!sub[RW+2]) begin
          rem_q[s]  <= sub[RW-1:0];
          root_q[s] <= {p_root[N-2:0], 1'b1};
        end else begin
          rem_q[s]  <= r_sh[RW-1:0];
          root_q[s] <= {p_root[N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld = vld[N-1];
  assign root    = root_q[N-1];
  assign tag_out = tag_q[N-1];

endmodule
`default_nettype wire

/* src/hsef_div.sv */
`default_nettype none
module hsef_div import hsef_pkg::*; #(
  parameter int N_W   = NUM_W,
  parameter int DEN_W = ROOT_W + DEF_FRAC_BITS,
  parameter int Q_W   = PK_W - DEF_FRAC_BITS,
  parameter int TAG_W = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_vld,
  input  wire logic [LANES-1:0][N_W-1:0]  num,
  input  wire logic [DEN_W-1:0]           den,
  input  wire logic [TAG_W-1:0]           tag_in,
  output logic                            out_vld,
  output logic [LANES-1:0][Q_W-1:0]       quo,
  output logic [TAG_W-1:0]                tag_out
);

  logic                        vld   [Q_W];
  logic [LANES-1:0][DEN_W-1:0] rem_q [Q_W];
  logic [LANES-1:0][Q_W-1:0]   low_q [Q_W];
  logic [DEN_W-1:0]            den_q [Q_W];
  logic [TAG_W-1:0]            tag_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic                        p_vld;
    logic [LANES-1:0][DEN_W-1:0] p_rem;
    logic [LANES-1:0][Q_W-1:0]   p_low;
    logic [DEN_W-1:0]            p_den;
    logic [TAG_W-1:0]            p_tag;
    logic [LANES-1:0][DEN_W-1:0] rem_n;
    logic [LANES-1:0][Q_W-1:0]   low_n;

    if (s == 0) begin : g_first
      assign p_vld = in_vld;
      assign p_den = den;
      assign p_tag = tag_in;
      for (genvar l = 0; l < LANES; l++) begin : g_init
        assign p_rem[l] = DEN_W'(num[l] >> Q_W);
        assign p_low[l] = num[l][Q_W-1:0];
      end
    end else begin : g_next
      assign p_vld = vld[s-1];
      assign p_rem = rem_q[s-1];
      assign p_low = low_q[s-1];
      assign p_den = den_q[s-1];
      assign p_tag = tag_q[s-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0]   r_sh;
      logic [DEN_W+1:0] sub;
      assign r_sh     = {p_rem[l], p_low[l][Q_W-1]};
      assign sub      = {1'b0, r_sh} - {2'b00, p_den};
      assign rem_n[l] = sub[DEN_W+1] ? r_sh[DEN_W-1:0] : sub[DEN_W-1:0];
      assign low_n[l] = {p_low[l][Q_W-2:0], ~sub[DEN_W+1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= rem_n;
        low_q[s] <= low_n;
        den_q[s] <= p_den;
        tag_q[s] <= p_tag;
      end
    end
  end

  assign out_vld = vld[Q_W-1];
  assign quo     = low_q[Q_W-1];
  assign tag_out = tag_q[Q_W-1];

endmodule
`default_nettype wire

/* src/harmonic_spring_energy_force.sv */
// Harmonic spring energy and gradient, one spring per item.
// Spring channel: spring_valid/spring_ready with atom indices, both
// atoms' coordinates, rest length, force constant and last_spring.
// Result channel: result_valid/result_ready with the indices, the energy
// term k/2*(d-L)^2, the gradient vector (subtract at the first atom, add
// at the second), zero_distance and last_out.
// Throughput: one item per cycle while the output is not stalled. The
// bit-per-stage square root and the bit-per-stage gradient dividers set
// the depth.
// The whole pipeline advances together: when a result waits and the
// receiver holds result_ready low, every stage holds and spring_ready
// drops; nothing is lost or repeated. Bubbles travel as empty stages.
// Reset clears every stage's valid bit; the block takes an item in the
// first cycle after reset.
// Coincident atoms give zero_distance = 1 and a zero gradient; the energy
// and gradient saturate at their field limits.
`default_nettype none
module harmonic_spring_energy_force import hsef_pkg::*; #(
  parameter int ATOM_INDEX_BITS = DEF_ATOM_INDEX_BITS,
  parameter int FRAC_BITS       = DEF_FRAC_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      spring_valid,
  output logic                           spring_ready,
  input  wire logic [IDX_W-1:0]          first_atom,
  input  wire logic [IDX_W-1:0]          second_atom,
  input  wire logic signed [COORD_W-1:0] first_x,
  input  wire logic signed [COORD_W-1:0] first_y,
  input  wire logic signed [COORD_W-1:0] first_z,
  input  wire logic signed [COORD_W-1:0] second_x,
  input  wire logic signed [COORD_W-1:0] second_y,
  input  wire logic signed [COORD_W-1:0] second_z,
  input  wire logic [COORD_W-1:0]        rest_length,
  input  wire logic [COORD_W-1:0]        force_constant,
  input  wire logic                      last_spring,
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output logic [IDX_W-1:0]               out_first_atom,
  output logic [IDX_W-1:0]               out_second_atom,
  output logic [ENERGY_W-1:0]            energy_term,
  output logic signed [GRAD_W-1:0]       grad_x,
  output logic signed [GRAD_W-1:0]       grad_y,
  output logic signed [GRAD_W-1:0]       grad_z,
  output logic                           zero_distance,
  output logic                           last_out
);

  localparam int DEN_W = ROOT_W + FRAC_BITS;
  localparam int Q_W   = PK_W - FRAC_BITS;
  localparam int E_SH  = 2 * FRAC_BITS + 1;
  localparam int SQ_TAG_W  = $bits(sq_tag_t);
  localparam int DIV_TAG_W = $bits(div_tag_t);
  localparam logic [IDX_W-1:0] IDX_MASK = (ATOM_INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} :
                                          IDX_W'((64'd1 << ATOM_INDEX_BITS) - 64'd1);

  logic en;
  assign en           = !result_valid || result_ready;
  assign spring_ready = en;

  // stage A: separation
  logic                                a_vld;
  sq_tag_t                             a_tag;
  logic [LANES-1:0][COORD_W-1:0]       in_p;
  logic [LANES-1:0][COORD_W-1:0]       in_q;
  sq_tag_t                             a_next;

  assign in_p = {first_z, first_y, first_x};
  assign in_q = {second_z, second_y, second_x};

  always_comb begin
    logic signed [DELTA_W-1:0] dl;
    a_next.ida  = first_atom & IDX_MASK;
    a_next.idb  = second_atom & IDX_MASK;
    a_next.last = last_spring;
    a_next.len  = rest_length;
    a_next.k    = force_constant;
    for (int i = 0; i < LANES; i++) begin
      dl = $signed({in_q[i][COORD_W-1], in_q[i]}) - $signed({in_p[i][COORD_W-1], in_p[i]});
      a_next.sgn[i]  = dl[DELTA_W-1];
      a_next.dmag[i] = dl[DELTA_W-1] ? MAG_W'(-dl) : MAG_W'(dl);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_tag <= a_next;
    end
  end

  // stage B: squares
  logic                          b_vld;
  sq_tag_t                       b_tag;
  logic [LANES-1:0][SQ_W-1:0]    b_sq;

  always_ff @(posedge clk) begin
    if (en) begin
      b_tag <= a_tag;
      for (int i = 0; i < LANES; i++) begin
        b_sq[i] <= SQ_W'(a_tag.dmag[i]) * SQ_W'(a_tag.dmag[i]);
      end
    end
  end

  // stage C: squared distance
  logic               c_vld;
  sq_tag_t            c_tag;
  logic [D2_W-1:0]    c_d2;

  always_ff @(posedge clk) begin
    if (en) begin
      c_tag <= b_tag;
      c_d2  <= D2_W'(b_sq[0]) + D2_W'(b_sq[1]) + D2_W'(b_sq[2]);
    end
  end

  logic                s_vld;
  logic [ROOT_W-1:0]   s_root;
  logic [SQ_TAG_W-1:0] s_tag_bits;
  sq_tag_t             s_tag;

  hsef_sqrt #(.RAD_W(D2_W), .TAG_W(SQ_TAG_W)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (c_vld),
    .rad     (c_d2),
    .tag_in  (c_tag),
    .out_vld (s_vld),
    .root    (s_root),
    .tag_out (s_tag_bits)
  );
  assign s_tag = sq_tag_t'(s_tag_bits);

  // stage D: distance minus rest length
  logic                      d_vld;
  sq_tag_t                   d_tag;
  logic [ROOT_W-1:0]         d_root;
  logic signed [DIFF_W-1:0]  d_diff;

  always_ff @(posedge clk) begin
    if (en) begin
      d_tag  <= s_tag;
      d_root <= s_root;
      d_diff <= $signed({1'b0, s_root}) - $signed({{(DIFF_W-COORD_W){1'b0}}, s_tag.len});
    end
  end

  // stage E: k*|diff| and |diff|^2
  logic                e_vld;
  sq_tag_t             e_tag;
  logic [ROOT_W-1:0]   e_root;
  logic                e_pos;
  logic                e_neg;
  logic [PK_W-1:0]     e_pk;
  logic [DSQ_W-1:0]    e_dsq;
  logic [ROOT_W-1:0]   d_mag;

  assign d_mag = d_diff[DIFF_W-1] ? ROOT_W'(-d_diff) : ROOT_W'(d_diff);

  always_ff @(posedge clk) begin
    if (en) begin
      e_tag  <= d_tag;
      e_root <= d_root;
      e_pos  <= !d_diff[DIFF_W-1] && (d_diff != '0);
      e_neg  <= d_diff[DIFF_W-1];
      e_pk   <= PK_W'(d_tag.k) * PK_W'(d_mag);
      e_dsq  <= DSQ_W'(d_mag) * DSQ_W'(d_mag);
    end
  end

  // stage F: partial products
  localparam int PH = PK_W / 2;
  localparam int EH = DSQ_W / 2;

  logic                         f_vld;
  sq_tag_t                      f_tag;
  logic [ROOT_W-1:0]            f_root;
  logic                         f_pos;
  logic                         f_neg;
  logic [LANES-1:0][SQ_W-1:0]   f_plo;
  logic [LANES-1:0][SQ_W-1:0]   f_phi;
  logic [PK_W-1:0]              f_elo;
  logic [PK_W-1:0]              f_ehi;

  always_ff @(posedge clk) begin
    if (en) begin
      f_tag  <= e_tag;
      f_root <= e_root;
      f_pos  <= e_pos;
      f_neg  <= e_neg;
      for (int i = 0; i < LANES; i++) begin
        f_plo[i] <= SQ_W'(e_pk[PH-1:0]) * SQ_W'(e_tag.dmag[i]);
        f_phi[i] <= SQ_W'(e_pk[PK_W-1:PH]) * SQ_W'(e_tag.dmag[i]);
      end
      f_elo <= PK_W'(e_dsq[EH-1:0]) * PK_W'(e_tag.k);
      f_ehi <= PK_W'(e_dsq[DSQ_W-1:EH]) * PK_W'(e_tag.k);
    end
  end

  // stage G: full products
  logic                         g_vld;
  sq_tag_t                      g_tag;
  logic [ROOT_W-1:0]            g_root;
  logic                         g_pos;
  logic                         g_neg;
  logic [LANES-1:0][NUM_W-1:0]  g_num;
  logic [ESUM_W-1:0]            g_esum;

  always_ff @(posedge clk) begin
    if (en) begin
      g_tag  <= f_tag;
      g_root <= f_root;
      g_pos  <= f_pos;
      g_neg  <= f_neg;
      for (int i = 0; i < LANES; i++) begin
        g_num[i] <= NUM_W'(f_plo[i]) + NUM_W'({f_phi[i], {PH{1'b0}}});
      end
      g_esum <= ESUM_W'(f_elo) + ESUM_W'({f_ehi, {EH{1'b0}}});
    end
  end

  logic [ESUM_W-1:0] e_sh;
  div_tag_t          g_dtag;

  assign e_sh = g_esum >> E_SH;

  always_comb begin
    g_dtag.ida    = g_tag.ida;
    g_dtag.idb    = g_tag.idb;
    g_dtag.last   = g_tag.last;
    g_dtag.zero   = (g_root == '0);
    g_dtag.energy = (|e_sh[ESUM_W-1:ENERGY_W]) ? ENERGY_MAX : e_sh[ENERGY_W-1:0];
    for (int i = 0; i < LANES; i++) begin
      g_dtag.neg[i] = (g_pos && !g_tag.sgn[i] && (g_tag.dmag[i] != '0)) ||
                      (g_neg && g_tag.sgn[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
    end else if (en) begin
      a_vld <= spring_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= s_vld;
      e_vld <= d_vld;
      f_vld <= e_vld;
      g_vld <= f_vld;
    end
  end

  logic                        q_vld;
  logic [LANES-1:0][Q_W-1:0]   q_quo;
  logic [DIV_TAG_W-1:0]        q_tag_bits;
  div_tag_t                    q_tag;

  hsef_div #(.N_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .TAG_W(DIV_TAG_W)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (g_vld),
    .num     (g_num),
    .den     ({g_root, {FRAC_BITS{1'b0}}}),
    .tag_in  (g_dtag),
    .out_vld (q_vld),
    .quo     (q_quo),
    .tag_out (q_tag_bits)
  );
  assign q_tag = div_tag_t'(q_tag_bits);

  // output stage: sign and saturate
  logic [LANES-1:0][GRAD_W-1:0] grad_next;

  always_comb begin
    logic [63:0] q64;
    logic [63:0] m;
    for (int i = 0; i < LANES; i++) begin
      q64 = 64'(q_quo[i]);
      m   = '0;
      if (q_tag.zero) begin
        grad_next[i] = '0;
      end else if (q_tag.neg[i]) begin
        m = (q64 > GRAD_NEG_MAG) ? GRAD_NEG_MAG : q64;
        grad_next[i] = -m[GRAD_W-1:0];
      end else begin
        grad_next[i] = (q64 > GRAD_POS_MAX) ? GRAD_POS_MAX[GRAD_W-1:0] : q64[GRAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_first_atom  <= q_tag.ida;
      out_second_atom <= q_tag.idb;
      energy_term     <= q_tag.energy;
      grad_x          <= grad_next[0];
      grad_y          <= grad_next[1];
      grad_z          <= grad_next[2];
      zero_distance   <= q_tag.zero;
      last_out        <= q_tag.last;
    end
  end

`ifndef SYNTHESIS
  a_zero_grad: assert property (@(posedge clk) disable iff (rst)
    result_valid && zero_distance |-> grad_x == '0 && grad_y == '0 && grad_z == '0)
    else $error("nonzero gradient on coincident atoms");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !spring_ready |-> result_valid && !result_ready)
    else $error("input stalled without a waiting result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(a_tag) && $stable(g_num))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
